// ===== src/newton_square_root_defines.svh =====
// assertion macros for the file that checks its own logic
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define NSR_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("same-cycle check failed");

// condition must hold in the cycle after the trigger
`define NSR_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("next-cycle check failed");

`endif

// ===== src/nsr_pkg.sv =====
package nsr_pkg;

    // fixed-point format and iteration bound
    localparam int FRAC_BITS = 16;
    localparam int MAX_STEPS = 32;

    // field widths
    localparam int RAD_W  = 32;
    localparam int TOL_W  = 16;
    localparam int ROOT_W = 25;
    localparam int STEP_W = 6;

    // internal widths: estimate, scaled radicand, divider bit counter
    localparam int X_W        = RAD_W;
    localparam int SCALED_W   = RAD_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(SCALED_W);

    localparam logic [RAD_W-1:0]  ONE_FX      = RAD_W'(1) << FRAC_BITS;
    localparam logic [X_W-1:0]    ROOT_MAX    = X_W'((64'd1 << ROOT_W) - 64'd1);
    localparam logic [STEP_W-1:0] STEP_LIMIT  = STEP_W'(MAX_STEPS);
    localparam logic [TOL_W-1:0]  TOL_RESET   = TOL_W'(1);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic update;
        logic out_load;
    } nsr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic below;
        logic div_done;
        logic iter_done;
    } nsr_status_t;

endpackage

// ===== src/nsr_div.sv =====
module nsr_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [nsr_pkg::SCALED_W-1:0] dividend,
    input  logic [nsr_pkg::X_W-1:0]      divisor,
    output logic                         done,
    output logic [nsr_pkg::SCALED_W-1:0] quotient
);
    import nsr_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SCALED_W-1:0]  dvd_reg, dvd_next;
    logic [X_W-1:0]       dvs_reg, dvs_next;
    logic [X_W-1:0]       rem_reg, rem_next;

    logic [X_W:0]         shifted;
    logic [X_W:0]         trial;
    logic                 fits;

    // one restoring quotient bit per cycle, quotient shifts into the dividend register
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[SCALED_W-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        trial    = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[X_W-1:0] : shifted[X_W-1:0];
            dvd_next = {dvd_reg[SCALED_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(SCALED_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and remainder registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== src/nsr_dp.sv =====
module nsr_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  nsr_pkg::nsr_cmd_t          cmd,
    output nsr_pkg::nsr_status_t       status,
    input  logic                       cfg_wr_en,
    input  logic [nsr_pkg::TOL_W-1:0]  cfg_wr_data,
    input  logic [nsr_pkg::RAD_W-1:0]  radicand,
    output logic [nsr_pkg::ROOT_W-1:0] root,
    output logic                       below_one,
    output logic [nsr_pkg::STEP_W-1:0] steps_taken,
    output logic                       step_cap_hit
);
    import nsr_pkg::*;

    logic [TOL_W-1:0]    tol_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [X_W-1:0]      x_reg;
    logic [STEP_W-1:0]   steps_reg;
    logic                below_reg;
    logic                stop_reg;

    logic [ROOT_W-1:0]   root_reg;
    logic                below_out_reg;
    logic [STEP_W-1:0]   steps_out_reg;
    logic                cap_out_reg;

    logic [RAD_W:0]      init_sum;
    logic [X_W-1:0]      x_init;
    logic [X_W-1:0]      divisor;
    logic                div_done;
    logic [SCALED_W-1:0] quotient;
    logic [SCALED_W:0]   step_sum;
    logic [X_W-1:0]      x_new;
    logic                step_stops;
    logic [ROOT_W-1:0]   root_sat;

    // start estimate (1 + a) / 2
    assign init_sum = {1'b0, radicand} + {1'b0, ONE_FX};
    assign x_init   = init_sum[X_W:1];

    // an estimate of zero divides as one
    assign divisor = (x_reg == '0) ? X_W'(1) : x_reg;

    nsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({rad_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // heron update and stop test
    assign step_sum   = {1'b0, quotient} + (SCALED_W + 1)'(x_reg);
    assign x_new      = step_sum[X_W:1];
    assign step_stops = (x_new >= x_reg) || ((x_reg - x_new) <= X_W'(tol_reg));

    // saturate to the root field
    assign root_sat = (x_reg > ROOT_MAX) ? ROOT_MAX[ROOT_W-1:0] : x_reg[ROOT_W-1:0];

    // tolerance register and iteration control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_RESET;
            steps_reg <= '0;
            below_reg <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                steps_reg <= '0;
                below_reg <= radicand < ONE_FX;
                stop_reg  <= 1'b0;
            end
            else if (cmd.update)
            begin
                steps_reg <= steps_reg + STEP_W'(1);
                stop_reg  <= step_stops;
            end
        end
    end

    // radicand and estimate
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rad_reg <= radicand;
            x_reg   <= x_init;
        end
        else if (cmd.update)
        begin
            x_reg <= x_new;
        end
    end

    // result register, held until the output transfer
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            root_reg      <= below_reg ? '0 : root_sat;
            below_out_reg <= below_reg;
            steps_out_reg <= below_reg ? '0 : steps_reg;
            cap_out_reg   <= !below_reg && !stop_reg;
        end
    end

    assign status.below     = below_reg;
    assign status.div_done  = div_done;
    assign status.iter_done = stop_reg || (steps_reg == STEP_LIMIT);

    assign root         = root_reg;
    assign below_one    = below_out_reg;
    assign steps_taken  = steps_out_reg;
    assign step_cap_hit = cap_out_reg;

endmodule

// ===== src/nsr_ctrl.sv =====
module nsr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  nsr_pkg::nsr_status_t status,
    output nsr_pkg::nsr_cmd_t    cmd
);
    import nsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EVAL,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // sequencing of one item: check, then divide and update per heron step
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.below)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.update = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.iter_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on result load, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/newton_square_root.sv =====
// Heron square root of an unsigned Q16.16 radicand, result in Q9.16. One item is
// worked at a time: a transfer on the input starts it, the result then sits in an
// output register while the next radicand is already taken. Each Heron step runs one
// serial 48-by-32 restoring division (one quotient bit per cycle) followed by an
// update and a stop test: a radicand below 1.0 skips the division and goes straight
// to the output, radicands from 1.0 up need 1 to about 13 steps, and the 32-step limit
// bounds the iteration. stop_tolerance (reset 1 LSB) may be written only while no
// item is in flight.
`include "newton_square_root_defines.svh"

module newton_square_root (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [nsr_pkg::TOL_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [nsr_pkg::RAD_W-1:0]  radicand,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [nsr_pkg::ROOT_W-1:0] root,
    output logic                       below_one,
    output logic [nsr_pkg::STEP_W-1:0] steps_taken,
    output logic                       step_cap_hit
);
    import nsr_pkg::*;

    nsr_cmd_t    cmd;
    nsr_status_t status;

    nsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    nsr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .radicand     (radicand),
        .root         (root),
        .below_one    (below_one),
        .steps_taken  (steps_taken),
        .step_cap_hit (step_cap_hit)
    );

    // a radicand under one gives an all-zero result
    `NSR_ASSERT_SAME(a_below_zero, out_valid && below_one, {root, steps_taken, step_cap_hit} == '0)

    // ending at the step limit means the limit was reached
    `NSR_ASSERT_SAME(a_cap_steps, out_valid && step_cap_hit, steps_taken == STEP_LIMIT)

    // a normal radicand takes at least one step and never more than the limit
    `NSR_ASSERT_SAME(a_steps_range, out_valid && !below_one, (steps_taken != '0) && (steps_taken <= STEP_LIMIT))

    // only one item in flight: input closes right after a transfer
    `NSR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import nsr_pkg::*;

    // one expected result of the root unit
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              below_one;
        logic [STEP_W-1:0] steps_taken;
        logic              step_cap_hit;
    } root_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [TOL_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [RAD_W-1:0]  radicand = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ROOT_W-1:0] root;
    logic              below_one;
    logic [STEP_W-1:0] steps_taken;
    logic              step_cap_hit;

    // local copy of the tolerance register and the roots still owed
    logic [TOL_W-1:0]  tol_model = TOL_RESET;
    root_result_t      pending_roots[$];
    root_result_t      want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int items_sent = 0;
    int below_sent = 0;
    int results_checked = 0;
    int deepest_steps = 0;
    int cap_hits = 0;

    newton_square_root u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .radicand     (radicand),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .root         (root),
        .below_one    (below_one),
        .steps_taken  (steps_taken),
        .step_cap_hit (step_cap_hit)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // overall run limit
    initial
    begin
        #60_000_000;
        $display("%0t: timeout with %0d roots outstanding", $time, pending_roots.size());
        $display("status: fail");
        $finish;
    end

    // heron iteration in fixed point, stops on a rise, a small decrease or the step limit
    function automatic root_result_t predict_root(input logic [RAD_W-1:0] a,
                                                  input logic [TOL_W-1:0] tol);
        root_result_t r;
        logic [63:0]  scaled;
        logic [63:0]  x;
        logic [63:0]  prev;
        logic [63:0]  divisor;
        int           n;
        bit           capped;
        r = '0;
        if (a < ONE_FX)
        begin
            r.below_one = 1'b1;
            return r;
        end
        scaled = {32'd0, a} << FRAC_BITS;
        x = (64'(ONE_FX) + 64'(a)) >> 1;
        n = 0;
        capped = 1'b1;
        while (n < MAX_STEPS)
        begin
            prev = x;
            divisor = (x == 64'd0) ? 64'd1 : x;
            x = (x + scaled / divisor) >> 1;
            n++;
            // a rise or a small enough drop ends the iteration
            if (x >= prev || (prev - x) <= 64'(tol))
            begin
                capped = 1'b0;
                break;
            end
        end
        r.root = (x > 64'(ROOT_MAX)) ? ROOT_W'(ROOT_MAX) : ROOT_W'(x);
        r.steps_taken = STEP_W'(n);
        r.step_cap_hit = capped;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, expected, actual);
        end
    endtask

    // result side: check each transfer, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_roots.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual root %0h",
                         $time, root);
            end
            else
            begin
                want = pending_roots.pop_front();
                check_field("root", 32'(want.root), 32'(root));
                check_field("below_one", 32'(want.below_one), 32'(below_one));
                check_field("steps_taken", 32'(want.steps_taken), 32'(steps_taken));
                check_field("step_cap_hit", 32'(want.step_cap_hit), 32'(step_cap_hit));
                results_checked++;
                if (int'(want.steps_taken) > deepest_steps)
                    deepest_steps = int'(want.steps_taken);
                if (want.step_cap_hit)
                    cap_hits++;
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one radicand transfer, with a random idle gap in front of it
    task automatic send_radicand(input logic [RAD_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        radicand <= value;
        pending_roots.push_back(predict_root(value, tol_model));
        items_sent++;
        if (value < ONE_FX)
            below_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold off the sender until every owed root has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // register write, only while the unit is idle
    task automatic set_tolerance(input logic [TOL_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tol_model = value;
    endtask

    // mix of value classes so every path and every bit gets exercised
    function automatic logic [RAD_W-1:0] random_radicand();
        logic [RAD_W-1:0] v;
        int unsigned      k;
        k = $urandom_range(1, 255);
        case ($urandom_range(9))
            0: v = $urandom_range(32'h0000_FFFF, 0);
            1: v = ONE_FX + $urandom_range(255, 0);
            2: v = ((k * k) << FRAC_BITS) + $urandom_range(3, 0);
            3: v = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
            4: v = {8'd0, 8'(k), 16'($urandom)};
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // field extremes and the below-one boundary at reset tolerance
    task automatic test_directed_edges();
        logic [RAD_W-1:0] edge_vals[16];
        edge_vals = '{32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'h0001_0000,
                      32'h0001_0001, 32'h0002_0000, 32'h0004_0000, 32'h0001_8000,
                      32'h0010_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
                      32'hFFFF_FFFF, 32'h5555_AAAA, 32'hAAAA_5555, 32'hFE01_0000};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (edge_vals[i])
            send_radicand(edge_vals[i]);
        drain_results();
    endtask

    // zero tolerance runs until the estimate stops falling, full tolerance stops early
    task automatic test_tolerance_extremes();
        logic [RAD_W-1:0] probe_vals[5];
        probe_vals = '{32'h0001_0000, 32'h0002_0000, 32'h0003_243F,
                       32'hFFFF_FFFF, 32'h0000_8000};
        set_tolerance('0);
        foreach (probe_vals[i])
            send_radicand(probe_vals[i]);
        drain_results();
        set_tolerance('1);
        foreach (probe_vals[i])
            send_radicand(probe_vals[i]);
        drain_results();
    endtask

    // random radicands under one handshake pressure, with a full pause midway
    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct, input logic [TOL_W-1:0] tol);
        set_tolerance(tol);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain_results();
            send_radicand(random_radicand());
        end
        drain_results();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_tolerance_extremes();
        test_random_traffic(140, 0, 0, TOL_RESET);
        test_random_traffic(140, 83, 0, '0);
        test_random_traffic(140, 0, 83, '1);
        test_random_traffic(140, 32, 32, TOL_W'($urandom_range(65535, 0)));

        recv_stall_pct = 0;
        repeat (50) @(posedge clk);

        $display("run covered %0d radicands (%0d under 1.0), %0d roots checked",
                 items_sent, below_sent, results_checked);
        $display("tolerances 0, 1, max and random; deepest iteration %0d steps, %0d capped",
                 deepest_steps, cap_hits);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/nsr_pkg.sv
src/nsr_div.sv
src/nsr_dp.sv
src/nsr_ctrl.sv
src/newton_square_root.sv
verif/tb.sv
